### hdl/elre_pkg.sv
// Shared types, constants and digit helpers for the event log record encoder.
package elre_pkg;

	// Base-251 arithmetic: x / 251 == (x * RECIP_251) >> RECIP_SHIFT for every 32-bit x
	localparam logic [31:0] RECIP_251   = 32'd2190262207;
	localparam int          RECIP_SHIFT = 39;

	// Input limits
	localparam logic [7:0]  MAX_EVENT = 8'd250;
	localparam logic [31:0] MAX_TIME  = 32'd3969126000;
	localparam logic [31:0] MAX_DELTA = 32'd237198765;
	localparam int          DELTA_W   = 28;

	// Delta length thresholds (inclusive upper bounds)
	localparam logic [DELTA_W-1:0] DLEN1_MAX = 28'd127;
	localparam logic [DELTA_W-1:0] DLEN2_MAX = 28'd15813;
	localparam logic [DELTA_W-1:0] DLEN3_MAX = 28'd1953031;

	// Length prefixes on the top delta digit, and the record terminator
	localparam logic [7:0] PFX2     = 8'd128;
	localparam logic [7:0] PFX3     = 8'd192;
	localparam logic [7:0] PFX4     = 8'd224;
	localparam logic [7:0] END_BYTE = 8'hFE;

	// Longest record and the count that walks it
	localparam int REC_MAX = 10;
	localparam int CNT_W   = 4;
	localparam int TAIL_N  = 5;

	// Register map
	typedef enum logic {
		REG_BASE_TIME = 1'b0
	} reg_idx_t;

	// Queue entry kind
	typedef enum logic {
		KIND_REC = 1'b0,
		KIND_ERR = 1'b1
	} kind_t;

	// Number of delta digits
	typedef enum logic [1:0] {
		DLEN_1 = 2'd0,
		DLEN_2 = 2'd1,
		DLEN_3 = 2'd2,
		DLEN_4 = 2'd3
	} dlen_t;

	// Input transaction
	typedef struct packed {
		logic [7:0]  event_code;
		logic [31:0] now_seconds;
	} evt_t;

	// Output transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_last;
		logic       error;
	} rec_t;

	// Classified work item between front and back
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         ev;
		logic [DELTA_W-1:0] delta;
		logic [31:0]        now;
	} job_t;

	// Converted digits handed to the serializer
	typedef struct packed {
		kind_t      kind;
		dlen_t      dlen;
		logic [7:0] ev;
		logic [7:0] dd0;
		logic [7:0] dd1;
		logic [7:0] dd2;
		logic [7:0] dtop;
		logic [7:0] nd3;
		logic [7:0] nd2;
		logic [7:0] nd1;
		logic [7:0] nd0;
	} conv_t;

	// Quotient by 251 through the reciprocal multiply
	function automatic logic [24:0] div251(input logic [31:0] x);
		logic [63:0] p;
		p = {32'd0, x} * {32'd0, RECIP_251};
		return p[63:RECIP_SHIFT];
	endfunction

	// Remainder by 251 from the low bytes: x - 251*q == x + 5*q (mod 256)
	function automatic logic [7:0] rem251(input logic [7:0] x8, input logic [7:0] q8);
		logic [7:0] q5;
		q5 = {q8[5:0], 2'b00} + q8;
		return x8 + q5;
	endfunction

endpackage

### hdl/elre_front.sv
// Front end: config register, time state, input classification.
module elre_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                evt_valid,
	output logic                evt_ready,
	input  elre_pkg::evt_t      evt,
	output logic                job_valid,
	output elre_pkg::job_t      job,
	input  logic                q_full
);

	logic [31:0] base_q;
	logic [31:0] prev_q;
	logic        has_prev_q;
	logic [31:0] prev;
	logic [31:0] diff;
	logic        bad;
	logic        reserved;
	logic        reg_hit;

	// Decode the register index from the word address
	assign reg_hit = (elre_pkg::reg_idx_t'(paddr[2]) == elre_pkg::REG_BASE_TIME);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? base_q : 32'd0;

	// Classify the incoming event against the previous time
	assign prev     = has_prev_q ? prev_q : base_q;
	assign diff     = evt.now_seconds - prev;
	assign reserved = (evt.event_code > elre_pkg::MAX_EVENT);
	assign bad      = (evt.now_seconds < prev) || (evt.now_seconds > elre_pkg::MAX_TIME)
			|| (diff > elre_pkg::MAX_DELTA);

	// Push every non-reserved transaction into the queue
	assign evt_ready = !q_full;
	assign job_valid = evt_valid && evt_ready && !reserved;

	always_comb begin
		job.kind  = bad ? elre_pkg::KIND_ERR : elre_pkg::KIND_REC;
		job.ev    = evt.event_code;
		job.delta = diff[elre_pkg::DELTA_W-1:0];
		job.now   = evt.now_seconds;
	end

	// Write base time from the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			base_q <= pwdata;
		end
	end

	// Advance the previous time on each good record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= 32'd0;
			has_prev_q <= 1'b0;
		end else if (job_valid && !bad) begin
			prev_q     <= evt.now_seconds;
			has_prev_q <= 1'b1;
		end
	end

endmodule

### hdl/elre_fifo.sv
// Short queue of classified items between front and back.
module elre_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  elre_pkg::job_t wdata,
	output logic           full,
	output logic           rvalid,
	input  logic           rready,
	output elre_pkg::job_t rdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	elre_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign rvalid = (cnt_q != '0);
	assign pop    = rvalid && rready;
	assign rdata  = mem_q[rptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/elre_conv.sv
// Back end, first half: base-251 digit conversion pipeline.
module elre_conv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  elre_pkg::job_t  in_job,
	output logic            out_valid,
	input  logic            out_ready,
	output elre_pkg::conv_t out_conv
);

	logic adv;
	logic v_s1, v_s2, v_s3;

	elre_pkg::job_t job_s1, job_s2, job_s3;
	logic [24:0]    q1d_s1, q1d_s2, q1d_s3;
	logic [24:0]    q1n_s1, q1n_s2, q1n_s3;
	logic [16:0]    q2d_s2, q2d_s3;
	logic [16:0]    q2n_s2, q2n_s3;
	logic [7:0]     q3d_s3, q3n_s3;

	logic [24:0] div_q2d, div_q2n, div_q3d, div_q3n;

	// Stall the whole pipe while the last stage waits
	assign adv       = !v_s3 || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_s3;

	assign div_q2d = elre_pkg::div251({7'd0, q1d_s1});
	assign div_q2n = elre_pkg::div251({7'd0, q1n_s1});
	assign div_q3d = elre_pkg::div251({15'd0, q2d_s2});
	assign div_q3n = elre_pkg::div251({15'd0, q2n_s2});

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Divide by 251 once per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1 <= in_job;
			q1d_s1 <= elre_pkg::div251({4'd0, in_job.delta});
			q1n_s1 <= elre_pkg::div251(in_job.now);

			job_s2 <= job_s1;
			q1d_s2 <= q1d_s1;
			q1n_s2 <= q1n_s1;
			q2d_s2 <= div_q2d[16:0];
			q2n_s2 <= div_q2n[16:0];

			job_s3 <= job_s2;
			q1d_s3 <= q1d_s2;
			q1n_s3 <= q1n_s2;
			q2d_s3 <= q2d_s2;
			q2n_s3 <= q2n_s2;
			q3d_s3 <= div_q3d[7:0];
			q3n_s3 <= div_q3n[7:0];
		end
	end

	// Form digits, length class and top digit, prefixed for two or more delta digits
	always_comb begin
		out_conv.kind = job_s3.kind;
		out_conv.ev   = job_s3.ev;
		out_conv.dd0  = elre_pkg::rem251(job_s3.delta[7:0], q1d_s3[7:0]);
		out_conv.dd1  = elre_pkg::rem251(q1d_s3[7:0], q2d_s3[7:0]);
		out_conv.dd2  = elre_pkg::rem251(q2d_s3[7:0], q3d_s3);
		out_conv.nd0  = elre_pkg::rem251(job_s3.now[7:0], q1n_s3[7:0]);
		out_conv.nd1  = elre_pkg::rem251(q1n_s3[7:0], q2n_s3[7:0]);
		out_conv.nd2  = elre_pkg::rem251(q2n_s3[7:0], q3n_s3);
		out_conv.nd3  = q3n_s3;

		priority if (job_s3.delta <= elre_pkg::DLEN1_MAX) begin
			out_conv.dlen = elre_pkg::DLEN_1;
		end else if (job_s3.delta <= elre_pkg::DLEN2_MAX) begin
			out_conv.dlen = elre_pkg::DLEN_2;
		end else if (job_s3.delta <= elre_pkg::DLEN3_MAX) begin
			out_conv.dlen = elre_pkg::DLEN_3;
		end else begin
			out_conv.dlen = elre_pkg::DLEN_4;
		end

		unique case (out_conv.dlen)
			elre_pkg::DLEN_1: begin
				out_conv.dtop = out_conv.dd0;
			end
			elre_pkg::DLEN_2: begin
				out_conv.dtop = elre_pkg::PFX2 + q1d_s3[7:0];
			end
			elre_pkg::DLEN_3: begin
				out_conv.dtop = elre_pkg::PFX3 + q2d_s3[7:0];
			end
			default: begin
				out_conv.dtop = elre_pkg::PFX4 + q3d_s3;
			end
		endcase
	end

endmodule

### hdl/elre_ser.sv
// Back end, second half: record byte serializer with output register.
module elre_ser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  elre_pkg::conv_t in_conv,
	output logic            rec_valid,
	input  logic            rec_ready,
	output elre_pkg::rec_t  rec
);

	logic [7:0]                sr_q [elre_pkg::REC_MAX];
	logic [elre_pkg::CNT_W-1:0] cnt_q;
	logic                      err_q;
	logic                      out_v_q;
	elre_pkg::rec_t            out_q;

	logic [7:0]                ld_bytes [elre_pkg::REC_MAX];
	logic [elre_pkg::CNT_W-1:0] ld_cnt;
	logic [7:0]                tail [elre_pkg::TAIL_N];
	logic                      free;
	logic                      emit;
	logic                      load;

	assign free      = !out_v_q || rec_ready;
	assign emit      = free && (cnt_q != '0);
	assign in_ready  = (cnt_q == '0) || ((cnt_q == elre_pkg::CNT_W'(1)) && free);
	assign load      = in_valid && in_ready;
	assign rec_valid = out_v_q;
	assign rec       = out_q;

	// Lay out the record bytes by delta length; an error entry is one zero byte
	always_comb begin
		tail[0] = in_conv.nd3;
		tail[1] = in_conv.nd2;
		tail[2] = in_conv.nd1;
		tail[3] = in_conv.nd0;
		tail[4] = elre_pkg::END_BYTE;
		for (int i = 0; i < elre_pkg::REC_MAX; i++) begin
			ld_bytes[i] = 8'd0;
		end
		ld_cnt = elre_pkg::CNT_W'(1);
		if (in_conv.kind == elre_pkg::KIND_REC) begin
			ld_bytes[0] = in_conv.ev;
			ld_bytes[1] = in_conv.dd0;
			unique case (in_conv.dlen)
				elre_pkg::DLEN_1: begin
					for (int i = 0; i < elre_pkg::TAIL_N; i++) ld_bytes[2 + i] = tail[i];
					ld_cnt = elre_pkg::CNT_W'(7);
				end
				elre_pkg::DLEN_2: begin
					ld_bytes[2] = in_conv.dtop;
					for (int i = 0; i < elre_pkg::TAIL_N; i++) ld_bytes[3 + i] = tail[i];
					ld_cnt = elre_pkg::CNT_W'(8);
				end
				elre_pkg::DLEN_3: begin
					ld_bytes[2] = in_conv.dd1;
					ld_bytes[3] = in_conv.dtop;
					for (int i = 0; i < elre_pkg::TAIL_N; i++) ld_bytes[4 + i] = tail[i];
					ld_cnt = elre_pkg::CNT_W'(9);
				end
				default: begin
					ld_bytes[2] = in_conv.dd1;
					ld_bytes[3] = in_conv.dd2;
					ld_bytes[4] = in_conv.dtop;
					for (int i = 0; i < elre_pkg::TAIL_N; i++) ld_bytes[5 + i] = tail[i];
					ld_cnt = elre_pkg::CNT_W'(10);
				end
			endcase
		end
	end

	// Load a new record or shift out one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ld_cnt;
		end else if (emit) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sr_q  <= ld_bytes;
			err_q <= (in_conv.kind == elre_pkg::KIND_ERR);
		end else if (emit) begin
			for (int i = 0; i < elre_pkg::REC_MAX - 1; i++) begin
				sr_q[i] <= sr_q[i + 1];
			end
			sr_q[elre_pkg::REC_MAX - 1] <= 8'd0;
		end
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (rec_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte <= sr_q[0];
			out_q.is_last  <= (cnt_q == elre_pkg::CNT_W'(1));
			out_q.error    <= err_q;
		end
	end

endmodule

### hdl/event_log_record_encoder_core.sv
// Top level of the event log record encoder.
//
//   channel   direction  handshake                 payload
//   evt       in         evt_valid / evt_ready     elre_pkg::evt_t (event_code, now_seconds)
//   rec       out        rec_valid / rec_ready     elre_pkg::rec_t (out_byte, is_last, error)
//   config    in         APB psel/penable/pready   base_time at byte address 0
//
// The front takes one transaction per cycle while the queue has room; reserved events
// are dropped there. The serializer sends one byte per cycle while the output is taken: a
// record is 7 to 10 bytes by its delta length, an error result one byte. The first byte
// passes through the queue, three divide stages, serializer load and output register.
// Reset clears the time state, base_time, the queue and all stage valids.
// Either side may stall at will; the queue and conversion pipe absorb the difference.
module event_log_record_encoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           evt_valid,
	output logic           evt_ready,
	input  elre_pkg::evt_t evt,
	output logic           rec_valid,
	input  logic           rec_ready,
	output elre_pkg::rec_t rec
);

	logic            job_valid;
	elre_pkg::job_t  job;
	logic            q_full;
	logic            q_rvalid;
	logic            q_rready;
	elre_pkg::job_t  q_rdata;
	logic            cv_valid;
	logic            cv_ready;
	elre_pkg::conv_t cv;

	elre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.job_valid (job_valid),
		.job       (job),
		.q_full    (q_full)
	);

	elre_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_valid),
		.wdata  (job),
		.full   (q_full),
		.rvalid (q_rvalid),
		.rready (q_rready),
		.rdata  (q_rdata)
	);

	elre_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_rvalid),
		.in_ready  (q_rready),
		.in_job    (q_rdata),
		.out_valid (cv_valid),
		.out_ready (cv_ready),
		.out_conv  (cv)
	);

	elre_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv_valid),
		.in_ready  (cv_ready),
		.in_conv   (cv),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

endmodule
